// ----- hdl/awbd_pkg.sv -----
package awbd_pkg;

  localparam int SCALE         = 4;
  localparam int SCALE_SQ      = SCALE * SCALE;
  localparam int MAX_OUT_WIDTH = 1024;
  localparam int MAX_OUT_ROWS  = 1024;

  localparam int SUB_W  = $clog2(SCALE);
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;

  // Sum widths follow from the block size: SCALE*SCALE bytes, or byte products.
  localparam int ASUM_W = $clog2(SCALE_SQ * 255 + 1);
  localparam int CSUM_W = $clog2(SCALE_SQ * 255 * 255 + 1);

  localparam int Q_W     = 8;
  localparam int Q_CNT_W = $clog2(Q_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS  = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] ROWS_RESET  = 11'd12;

  typedef struct packed {
    logic [7:0] in_alpha;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_t;

  typedef struct packed {
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [7:0] avg_alpha;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
  } result_t;

  typedef struct packed {
    pixel_t             pix;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               sub_first;
    logic               sub_last;
    logic               band_first;
    logic               block_last;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic [ASUM_W-1:0] asum;
    logic [CSUM_W-1:0] rsum;
    logic [CSUM_W-1:0] gsum;
    logic [CSUM_W-1:0] bsum;
  } sums_t;

  typedef struct packed {
    logic              start;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [7:0]        alpha;
    logic [ASUM_W-1:0] divisor;
    logic [CSUM_W-1:0] rsum;
    logic [CSUM_W-1:0] gsum;
    logic [CSUM_W-1:0] bsum;
  } div_cmd_t;

endpackage

// ----- hdl/alpha_weighted_box_downsampler_unit.sv -----
// Alpha-weighted 4x4 box downsampler. Source pixels enter in raster order at
// one word per cycle; out_width and out_rows set the output grid and may be
// written only while the block is idle. The front counts raster position and
// feeds a four-entry queue; the back keeps per-column sums in a 1024-entry
// memory, taking a column's stored sum at the start of each sub-row run and
// writing it back at its end. When a block's last pixel arrives with a nonzero
// alpha sum, a bit-serial divider takes eight quotient steps for the averaged
// colors, and the result word is registered in a single output slot until it
// is popped. Input is stalled only when a block completes while the divider
// is still busy with the previous one, or when a finished result is not
// popped and the queue fills behind it.
module alpha_weighted_box_downsampler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [awbd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [awbd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              push,
  output logic                              full,
  input  awbd_pkg::pixel_t                  in_data,
  output logic                              empty,
  input  logic                              pop,
  output awbd_pkg::result_t                 out_data
);

  logic               q_push, q_pop, div_busy;
  awbd_pkg::item_t    q_item, q_head;
  awbd_pkg::qstat_t   q_st;
  awbd_pkg::div_cmd_t div_cmd;

  assign full = q_st.full;

  awbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .push     (push),
    .in_data  (in_data),
    .q_st     (q_st),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  awbd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_item (q_item),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_st   (q_st)
  );

  awbd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_st     (q_st),
    .q_pop    (q_pop),
    .div_busy (div_busy),
    .div_cmd  (div_cmd)
  );

  awbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_cmd  (div_cmd),
    .div_busy (div_busy),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.start |-> !div_busy)
    else $error("divider started while busy");

  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("queue popped while empty");

  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.full |-> !q_push)
    else $error("queue written while full");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result pending after reset");

endmodule

// ----- hdl/awbd_front.sv -----
module awbd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [awbd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [awbd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              push,
  input  awbd_pkg::pixel_t                  in_data,
  input  awbd_pkg::qstat_t                  q_st,
  output logic                              q_push,
  output awbd_pkg::item_t                   q_item
);

  logic [awbd_pkg::CFG_W-1:0] width_r, rows_r;
  logic [awbd_pkg::SUB_W-1:0] sub_col_r, sub_col_nxt, sub_row_r, sub_row_nxt;
  logic [awbd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [awbd_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [awbd_pkg::CFG_W-1:0] eff_w, eff_h, col_inc, row_inc;
  logic                       sub_col_end, sub_row_end;

  always_comb begin
    if (width_r == '0) begin
      eff_w = awbd_pkg::CFG_W'(1);
    end else if (width_r > awbd_pkg::CFG_W'(awbd_pkg::MAX_OUT_WIDTH)) begin
      eff_w = awbd_pkg::CFG_W'(awbd_pkg::MAX_OUT_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (rows_r == '0) begin
      eff_h = awbd_pkg::CFG_W'(1);
    end else if (rows_r > awbd_pkg::CFG_W'(awbd_pkg::MAX_OUT_ROWS)) begin
      eff_h = awbd_pkg::CFG_W'(awbd_pkg::MAX_OUT_ROWS);
    end else begin
      eff_h = rows_r;
    end
  end

  assign sub_col_end = (sub_col_r == awbd_pkg::SUB_W'(awbd_pkg::SCALE - 1));
  assign sub_row_end = (sub_row_r == awbd_pkg::SUB_W'(awbd_pkg::SCALE - 1));
  assign col_inc     = awbd_pkg::CFG_W'(col_r) + awbd_pkg::CFG_W'(1);
  assign row_inc     = awbd_pkg::CFG_W'(row_r) + awbd_pkg::CFG_W'(1);
  assign q_push      = push && !q_st.full;

  // Raster counters; a counter that reaches its (possibly new) limit wraps.
  always_comb begin
    sub_col_nxt = sub_col_r;
    col_nxt     = col_r;
    sub_row_nxt = sub_row_r;
    row_nxt     = row_r;
    if (q_push) begin
      sub_col_nxt = sub_col_r + awbd_pkg::SUB_W'(1);
      if (sub_col_end) begin
        sub_col_nxt = '0;
        if (col_inc >= eff_w) begin
          col_nxt     = '0;
          sub_row_nxt = sub_row_r + awbd_pkg::SUB_W'(1);
          if (sub_row_end) begin
            sub_row_nxt = '0;
            if (row_inc >= eff_h) begin
              row_nxt = '0;
            end else begin
              row_nxt = row_inc[awbd_pkg::ROW_W-1:0];
            end
          end
        end else begin
          col_nxt = col_inc[awbd_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= awbd_pkg::WIDTH_RESET;
      rows_r    <= awbd_pkg::ROWS_RESET;
      sub_col_r <= '0;
      col_r     <= '0;
      sub_row_r <= '0;
      row_r     <= '0;
    end else begin
      sub_col_r <= sub_col_nxt;
      col_r     <= col_nxt;
      sub_row_r <= sub_row_nxt;
      row_r     <= row_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          awbd_pkg::REG_OUT_WIDTH: width_r <= cfg_data;
          awbd_pkg::REG_OUT_ROWS:  rows_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    q_item            = '0;
    q_item.pix        = in_data;
    q_item.col        = col_r;
    q_item.row        = row_r;
    q_item.sub_first  = (sub_col_r == '0);
    q_item.sub_last   = sub_col_end;
    q_item.band_first = (sub_row_r == '0);
    q_item.block_last = sub_col_end && sub_row_end;
  end

endmodule

// ----- hdl/awbd_queue.sv -----
module awbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  awbd_pkg::item_t   q_item,
  input  logic              q_pop,
  output awbd_pkg::item_t   q_head,
  output awbd_pkg::qstat_t  q_st
);

  awbd_pkg::item_t             slot_r [awbd_pkg::QUEUE_DEPTH];
  logic [awbd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [awbd_pkg::QPTR_W:0]   count_r;

  assign q_head   = slot_r[rd_ptr_r];
  assign q_st.empty = (count_r == '0);
  assign q_st.full  = (count_r == (awbd_pkg::QPTR_W+1)'(awbd_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + awbd_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + awbd_pkg::QPTR_W'(1);
      end
      case ({q_push, q_pop})
        2'b10:   count_r <= count_r + (awbd_pkg::QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (awbd_pkg::QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hdl/awbd_back.sv -----
module awbd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  awbd_pkg::item_t    q_head,
  input  awbd_pkg::qstat_t   q_st,
  output logic               q_pop,
  input  logic               div_busy,
  output awbd_pkg::div_cmd_t div_cmd
);

  awbd_pkg::sums_t sum_mem [awbd_pkg::MAX_OUT_WIDTH];

  awbd_pkg::item_t item_r;
  logic            item_v_r;
  awbd_pkg::sums_t rd_r, byp_r, acc_r;
  logic            byp_v_r;

  awbd_pkg::sums_t base, src, acc_nxt;
  logic [15:0]     prod_red, prod_green, prod_blue;
  logic            is_out, consume, advance, wr_en;

  assign prod_red   = item_r.pix.in_red   * item_r.pix.in_alpha;
  assign prod_green = item_r.pix.in_green * item_r.pix.in_alpha;
  assign prod_blue  = item_r.pix.in_blue  * item_r.pix.in_alpha;

  always_comb begin
    if (item_r.band_first) begin
      base = '0;
    end else if (byp_v_r) begin
      base = byp_r;
    end else begin
      base = rd_r;
    end
    src          = item_r.sub_first ? base : acc_r;
    acc_nxt.asum = src.asum + awbd_pkg::ASUM_W'(item_r.pix.in_alpha);
    acc_nxt.rsum = src.rsum + awbd_pkg::CSUM_W'(prod_red);
    acc_nxt.gsum = src.gsum + awbd_pkg::CSUM_W'(prod_green);
    acc_nxt.bsum = src.bsum + awbd_pkg::CSUM_W'(prod_blue);
  end

  assign is_out  = item_r.block_last && (acc_nxt.asum != '0);
  assign consume = item_v_r && !(is_out && div_busy);
  assign advance = !item_v_r || consume;
  assign q_pop   = advance && !q_st.empty;
  assign wr_en   = consume && item_r.sub_last;

  // A sub-row's run is summed in acc_r and written back once at its end.
  // The next sub-row of the same column may be read at that very edge,
  // so the fresh sum is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[item_r.col] <= acc_nxt;
    end
    if (q_pop) begin
      rd_r <= sum_mem[q_head.col];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r  <= q_head;
      byp_r   <= acc_nxt;
    end
    if (consume) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      byp_v_r  <= 1'b0;
    end else begin
      if (advance) begin
        item_v_r <= q_pop;
      end
      if (q_pop) begin
        byp_v_r <= wr_en && (item_r.col == q_head.col);
      end
    end
  end

  always_comb begin
    div_cmd         = '0;
    div_cmd.start   = consume && is_out;
    div_cmd.col     = item_r.col;
    div_cmd.row     = item_r.row;
    div_cmd.alpha   = 8'(acc_nxt.asum / awbd_pkg::SCALE_SQ);
    div_cmd.divisor = acc_nxt.asum;
    div_cmd.rsum    = acc_nxt.rsum;
    div_cmd.gsum    = acc_nxt.gsum;
    div_cmd.bsum    = acc_nxt.bsum;
  end

endmodule

// ----- hdl/awbd_div.sv -----
module awbd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  awbd_pkg::div_cmd_t div_cmd,
  output logic               div_busy,
  input  logic               pop,
  output logic               empty,
  output awbd_pkg::result_t  out_data
);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_RUN  = 3'b010,
    DS_DONE = 3'b100
  } div_state_t;

  div_state_t                   state_r, state_nxt;
  logic [awbd_pkg::Q_CNT_W-1:0] step_r;
  logic [awbd_pkg::CSUM_W-1:0]  dsh_r;
  logic [awbd_pkg::CSUM_W-1:0]  rem_r [3];
  logic [awbd_pkg::Q_W-1:0]     quo_r [3];
  logic [awbd_pkg::COL_W-1:0]   col_r;
  logic [awbd_pkg::ROW_W-1:0]   row_r;
  logic [7:0]                   alpha_r;
  awbd_pkg::result_t            res_r;
  logic                         res_v_r;
  logic                         slot_free;
  logic                         last_step;

  assign div_busy  = (state_r != DS_IDLE);
  assign slot_free = !res_v_r || pop;
  assign last_step = (step_r == awbd_pkg::Q_CNT_W'(awbd_pkg::Q_W - 1));
  assign empty     = !res_v_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DS_IDLE: if (div_cmd.start) state_nxt = DS_RUN;
      DS_RUN:  if (last_step) state_nxt = DS_DONE;
      DS_DONE: if (slot_free) state_nxt = DS_IDLE;
      default: state_nxt = DS_IDLE;
    endcase
  end

  // Restoring division, one quotient bit per cycle in each color lane.
  // In range the quotient never exceeds one byte.
  always_ff @(posedge clk) begin
    if (state_r == DS_IDLE && div_cmd.start) begin
      rem_r[0] <= div_cmd.rsum;
      rem_r[1] <= div_cmd.gsum;
      rem_r[2] <= div_cmd.bsum;
      dsh_r    <= awbd_pkg::CSUM_W'(div_cmd.divisor) << (awbd_pkg::Q_W - 1);
      step_r   <= '0;
      col_r    <= div_cmd.col;
      row_r    <= div_cmd.row;
      alpha_r  <= div_cmd.alpha;
      for (int i = 0; i < 3; i++) begin
        quo_r[i] <= '0;
      end
    end else if (state_r == DS_RUN) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= dsh_r) begin
          rem_r[i] <= rem_r[i] - dsh_r;
          quo_r[i] <= {quo_r[i][awbd_pkg::Q_W-2:0], 1'b1};
        end else begin
          quo_r[i] <= {quo_r[i][awbd_pkg::Q_W-2:0], 1'b0};
        end
      end
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r + awbd_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DS_DONE && slot_free) begin
      res_r.out_x     <= col_r;
      res_r.out_y     <= row_r;
      res_r.avg_alpha <= alpha_r;
      res_r.avg_red   <= quo_r[0];
      res_r.avg_green <= quo_r[1];
      res_r.avg_blue  <= quo_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == DS_DONE && slot_free) begin
        res_v_r <= 1'b1;
      end else if (pop) begin
        res_v_r <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/tb_alpha_weighted_box_downsampler_unit.sv -----
`timescale 1ns / 1ps

module tb_alpha_weighted_box_downsampler_unit;

  localparam int PIXEL_TARGET  = 1100;
  localparam int DRAIN_CYCLES  = 40;

  typedef enum int {MIX_ALPHA, CLEAR_ALPHA, SOLID_ALPHA} alpha_mix_t;

  class box_average_scoreboard;
    int unsigned alpha_acc [awbd_pkg::MAX_OUT_WIDTH];
    int unsigned red_acc [awbd_pkg::MAX_OUT_WIDTH];
    int unsigned green_acc [awbd_pkg::MAX_OUT_WIDTH];
    int unsigned blue_acc [awbd_pkg::MAX_OUT_WIDTH];
    int unsigned sub_col;
    int unsigned col_idx;
    int unsigned sub_row;
    int unsigned row_idx;
    logic [awbd_pkg::CFG_W-1:0] width_reg;
    logic [awbd_pkg::CFG_W-1:0] rows_reg;
    awbd_pkg::result_t pending_averages [$];
    int unsigned mismatches;

    function new();
      sub_col = 0;
      col_idx = 0;
      sub_row = 0;
      row_idx = 0;
      width_reg = awbd_pkg::WIDTH_RESET;
      rows_reg = awbd_pkg::ROWS_RESET;
      mismatches = 0;
    endfunction

    function int unsigned width_limit(logic [awbd_pkg::CFG_W-1:0] w);
      if (w == 0) return 1;
      if (w > awbd_pkg::MAX_OUT_WIDTH) return awbd_pkg::MAX_OUT_WIDTH;
      return w;
    endfunction

    function void write_reg(logic [awbd_pkg::CFG_IDX_W-1:0] idx,
                            logic [awbd_pkg::CFG_W-1:0] data);
      case (idx)
        awbd_pkg::REG_OUT_WIDTH: width_reg = data;
        awbd_pkg::REG_OUT_ROWS: rows_reg = data;
        default: ;
      endcase
    endfunction

    function void accumulate_pixel(awbd_pkg::pixel_t pix);
      int unsigned col;
      int unsigned sa;
      int unsigned row_limit;
      awbd_pkg::result_t avg;
      col = col_idx % awbd_pkg::MAX_OUT_WIDTH;
      // The first pixel of a block opens the column sums; the rest add to them.
      if (sub_row == 0 && sub_col == 0) begin
        alpha_acc[col] = pix.in_alpha;
        red_acc[col] = 32'(pix.in_red) * 32'(pix.in_alpha);
        green_acc[col] = 32'(pix.in_green) * 32'(pix.in_alpha);
        blue_acc[col] = 32'(pix.in_blue) * 32'(pix.in_alpha);
      end else begin
        alpha_acc[col] += pix.in_alpha;
        red_acc[col] += 32'(pix.in_red) * 32'(pix.in_alpha);
        green_acc[col] += 32'(pix.in_green) * 32'(pix.in_alpha);
        blue_acc[col] += 32'(pix.in_blue) * 32'(pix.in_alpha);
      end
      if (sub_row == awbd_pkg::SCALE - 1 && sub_col == awbd_pkg::SCALE - 1 &&
          alpha_acc[col] != 0) begin
        sa = alpha_acc[col];
        avg.out_x = 10'(col);
        avg.out_y = 10'(row_idx);
        avg.avg_alpha = 8'(sa / awbd_pkg::SCALE_SQ);
        avg.avg_red = 8'(red_acc[col] / sa);
        avg.avg_green = 8'(green_acc[col] / sa);
        avg.avg_blue = 8'(blue_acc[col] / sa);
        pending_averages.push_back(avg);
      end
      row_limit = (rows_reg == 0) ? 1 :
                  ((rows_reg > awbd_pkg::MAX_OUT_ROWS) ? awbd_pkg::MAX_OUT_ROWS : rows_reg);
      sub_col++;
      if (sub_col >= awbd_pkg::SCALE) begin
        sub_col = 0;
        col_idx++;
        if (col_idx >= width_limit(width_reg)) begin
          col_idx = 0;
          sub_row++;
          if (sub_row >= awbd_pkg::SCALE) begin
            sub_row = 0;
            row_idx++;
            if (row_idx >= row_limit) row_idx = 0;
          end
        end
      end
    endfunction

    function void compare_field(string name, logic [9:0] want, logic [9:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_average(awbd_pkg::result_t got);
      awbd_pkg::result_t want;
      if (pending_averages.size() == 0) begin
        $error("result word with nothing expected: x %0d, y %0d", got.out_x, got.out_y);
        mismatches++;
        return;
      end
      want = pending_averages.pop_front();
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("avg_alpha", 10'(want.avg_alpha), 10'(got.avg_alpha));
      compare_field("avg_red", 10'(want.avg_red), 10'(got.avg_red));
      compare_field("avg_green", 10'(want.avg_green), 10'(got.avg_green));
      compare_field("avg_blue", 10'(want.avg_blue), 10'(got.avg_blue));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [awbd_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [awbd_pkg::CFG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  awbd_pkg::pixel_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  awbd_pkg::result_t out_data;

  box_average_scoreboard board;
  bit no_idle = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned pop_hold = 0;

  alpha_weighted_box_downsampler_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls in short bursts so that results and then the input queue can back up.
  always @(negedge clk) begin
    if (no_idle) begin
      pop_hold = 0;
    end else if (pop_hold > 0) begin
      pop_hold--;
    end else if ($urandom_range(0, 99) < 2) begin
      pop_hold = $urandom_range(1, 9);
    end
    pop = rst_n && (pop_hold == 0);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) board.compare_average(out_data);
  end

  function automatic awbd_pkg::pixel_t random_pixel(alpha_mix_t mix);
    awbd_pkg::pixel_t pix;
    int unsigned pick;
    pix = awbd_pkg::pixel_t'($urandom);
    pick = $urandom_range(0, 99);
    case (mix)
      CLEAR_ALPHA: if (pick < 90) pix.in_alpha = 8'h00;
      SOLID_ALPHA: if (pick < 80) pix.in_alpha = 8'hff;
      default: begin
        if (pick < 15) pix.in_alpha = 8'h00;
        else if (pick < 25) pix.in_alpha = 8'hff;
        else if (pick < 30) pix.in_alpha = 8'h01;
      end
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      pix.in_red = 8'h00;
      pix.in_green = 8'h00;
      pix.in_blue = 8'h00;
    end else if (pick == 1) begin
      pix.in_red = 8'hff;
      pix.in_green = 8'hff;
      pix.in_blue = 8'hff;
    end
    return pix;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(awbd_pkg::pixel_t pix);
    while (!no_idle && $urandom_range(0, 99) < 10) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_data = pix;
    @(posedge clk);
    while (full) @(posedge clk);
    board.accumulate_pixel(pix);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_averages();
    push = 1'b0;
    while (board.pending_averages.size() != 0) @(posedge clk);
    // A block with zero alpha may still be in flight with nothing to show for it.
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [awbd_pkg::CFG_IDX_W-1:0] idx,
                           logic [awbd_pkg::CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(idx, data);
  endtask

  task automatic reshape_grid(logic [awbd_pkg::CFG_W-1:0] width,
                              logic [awbd_pkg::CFG_W-1:0] rows,
                              alpha_mix_t mix);
    // Widening after the first sub-row of a band would reach columns whose sums
    // were never opened, so finish the band first.
    if (board.width_limit(width) > board.width_limit(board.width_reg)) begin
      while (board.sub_row != 0) send_pixel(random_pixel(mix));
    end
    drain_averages();
    write_reg(awbd_pkg::REG_OUT_WIDTH, width);
    write_reg(awbd_pkg::REG_OUT_ROWS, rows);
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned pick;
    alpha_mix_t mix;
    logic [awbd_pkg::CFG_W-1:0] width;
    logic [awbd_pkg::CFG_W-1:0] rows;
    logic [7:0] alpha;
    awbd_pkg::pixel_t pix;

    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Oversized registers clamp to the full grid; open column 0 at that width.
    write_reg(awbd_pkg::REG_OUT_WIDTH, 11'd2047);
    write_reg(awbd_pkg::REG_OUT_ROWS, 11'd2047);
    send_pixel(awbd_pkg::pixel_t'({8'hff, 8'hff, 8'hff, 8'hff}));
    send_pixel(awbd_pkg::pixel_t'({8'h01, 8'h00, 8'hff, 8'h80}));
    send_pixel(awbd_pkg::pixel_t'({8'h00, 8'h12, 8'h34, 8'h56}));
    send_pixel(awbd_pkg::pixel_t'({8'h80, 8'h00, 8'h00, 8'hff}));
    // Narrow the grid mid-band; column 1 stays fully transparent, so it
    // gives no result, while column 0 completes with mixed alpha.
    drain_averages();
    write_reg(awbd_pkg::REG_OUT_WIDTH, 11'd2);
    for (int k = 0; k < 28; k++) begin
      pix = awbd_pkg::pixel_t'($urandom);
      if ((k / 4) % 2 == 1) begin
        case (k % 4)
          0: alpha = 8'hff;
          1: alpha = 8'h00;
          2: alpha = 8'h01;
          default: alpha = 8'($urandom);
        endcase
        pix.in_alpha = alpha;
        if (k % 4 == 0) begin
          pix.in_red = 8'hff;
          pix.in_green = 8'h00;
          pix.in_blue = 8'hff;
        end
      end else begin
        pix.in_alpha = 8'h00;
      end
      send_pixel(pix);
    end

    phase = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      mix = MIX_ALPHA;
      phase_len = $urandom_range(40, 160);
      case (phase)
        0: begin
          width = 11'd0;
          rows = 11'd0;
        end
        1: begin
          width = 11'd1024;
          rows = 11'd1024;
          phase_len = 80;
        end
        2: begin
          width = 11'd3;
          rows = 11'd2047;
        end
        3: begin
          width = 11'd1;
          rows = 11'd1;
          phase_len = 240;
        end
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 5) width = 11'd0;
          else if (pick < 10) width = 11'd2047;
          else if (pick < 15) width = 11'd1024;
          else if (pick < 25) width = 11'($urandom_range(9, 24));
          else width = 11'($urandom_range(1, 8));
          pick = $urandom_range(0, 99);
          if (pick < 10) rows = 11'd0;
          else if (pick < 20) rows = 11'd2047;
          else if (pick < 30) rows = 11'd1024;
          else if (pick < 40) rows = 11'($urandom_range(1, 1024));
          else rows = 11'($urandom_range(1, 4));
          pick = $urandom_range(0, 99);
          if (pick < 15) mix = CLEAR_ALPHA;
          else if (pick < 30) mix = SOLID_ALPHA;
        end
      endcase
      reshape_grid(width, rows, mix);
      no_idle = (phase == 3);
      repeat (phase_len) send_pixel(random_pixel(mix));
      no_idle = 1'b0;
      phase++;
    end

    drain_averages();
    if (board.mismatches == 0) begin
      $display("tb_alpha_weighted_box_downsampler_unit: PASS");
    end else begin
      $display("tb_alpha_weighted_box_downsampler_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_alpha_weighted_box_downsampler_unit: FAIL");
    $finish;
  end

endmodule
